[rtl/twsm_pkg.sv]
// ----------------------------------------------------------------------------
// twsm_pkg
// Types and constants shared by the trajectory window smoother modules.
// ----------------------------------------------------------------------------
`default_nettype none
package twsm_pkg;
	localparam int RING_DEPTH = 64;
	localparam int RING_AW    = 6;
	localparam int ACC_W      = 48;
	localparam int SUM_W      = 54;
	localparam int DIV_W      = 55;
	localparam int OUT_W      = 32;
	localparam int CNT_W      = 7;
	localparam int DIV_STEPS  = DIV_W;
	localparam logic [4:0] RADIUS_RESET = 5'(50 / 2);

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic               run_load;
		logic               run_clear;
		logic               ram_we;
		logic [RING_AW-1:0] ram_waddr;
		logic [RING_AW-1:0] ram_raddr;
		logic               sum_clear;
		logic               sum_rd;
		logic               prev_rd;
		logic               prev_use;
		logic               div_load;
		logic               div_step;
		logic [CNT_W-1:0]   count;
		logic               out_load;
		logic               out_last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

[rtl/twsm_if.sv]
// ----------------------------------------------------------------------------
// twsm_in_if / twsm_out_if
// Valid/ready channels for motion items and corrected results.
// ----------------------------------------------------------------------------
`default_nettype none
interface twsm_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] shift_x;
	logic [31:0] shift_y;
	logic [31:0] turn;
	logic        final_frame;
	modport source (output valid, shift_x, shift_y, turn, final_frame, input ready);
	modport sink   (input valid, shift_x, shift_y, turn, final_frame, output ready);
endinterface

interface twsm_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] fixed_x;
	logic [31:0] fixed_y;
	logic [31:0] fixed_turn;
	logic        sequence_end;
	modport source (output valid, fixed_x, fixed_y, fixed_turn, sequence_end, input ready);
	modport sink   (input valid, fixed_x, fixed_y, fixed_turn, sequence_end, output ready);
endinterface
`default_nettype wire

[rtl/trajectory_window_smoother.sv]
// ----------------------------------------------------------------------------
// trajectory_window_smoother
// Centred moving-average trajectory smoothing of frame motion, Q16.16.
// ----------------------------------------------------------------------------
// An accepted input starts a result once the pending frame count exceeds
// the radius, or on a final frame; the window of N frames (1 to 63) is
// walked serially over the ring RAM and divided in the 55-step restoring
// divider of each channel. A final frame emits all pending results in turn.
// A stalled result sink adds its stall cycles before the next result starts.
// Reset clears all control state and sets the radius register to 25.
`default_nettype none
module trajectory_window_smoother (
	input  wire logic       clk,
	input  wire logic       arst_n,
	twsm_in_if.sink         motion,
	twsm_out_if.source      fixed,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_data
);
	twsm_pkg::cmd_t cmd;
	twsm_pkg::sts_t sts;

	twsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (motion.valid),
		.in_ready (motion.ready),
		.in_final (motion.final_frame),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

	twsm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.shift_x      (motion.shift_x),
		.shift_y      (motion.shift_y),
		.turn         (motion.turn),
		.out_valid    (fixed.valid),
		.out_ready    (fixed.ready),
		.fixed_x      (fixed.fixed_x),
		.fixed_y      (fixed.fixed_y),
		.fixed_turn   (fixed.fixed_turn),
		.sequence_end (fixed.sequence_end)
	);
endmodule
`default_nettype wire

[rtl/twsm_ram.sv]
// ----------------------------------------------------------------------------
// twsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module twsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/twsm_datapath.sv]
// ----------------------------------------------------------------------------
// twsm_datapath
// Running sums, trajectory ring, window sums, dividers and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module twsm_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire twsm_pkg::cmd_t cmd,
	output twsm_pkg::sts_t     sts,
	input  wire logic [31:0]   shift_x,
	input  wire logic [31:0]   shift_y,
	input  wire logic [31:0]   turn,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [31:0]        fixed_x,
	output logic [31:0]        fixed_y,
	output logic [31:0]        fixed_turn,
	output logic               sequence_end
);
	localparam int AW = twsm_pkg::ACC_W;
	localparam int SW = twsm_pkg::SUM_W;
	localparam int DW = twsm_pkg::DIV_W;
	localparam int RW = DW + 2;

	twsm_pkg::acc_t        run_q   [3];
	twsm_pkg::acc_t        run_n   [3];
	logic signed [SW-1:0]  sum_q   [3];
	twsm_pkg::acc_t        prev_q  [3];
	logic [DW-1:0]         quo_q   [3];
	logic [5:0]            rem_q   [3];
	logic                  neg_q   [3];
	logic [31:0]           res     [3];
	logic [31:0]           in_val  [3];
	logic [3*AW-1:0]       wdata;
	logic [3*AW-1:0]       rdata;
	logic                  sum_rd_s1;
	logic                  prev_rd_s1;
	logic                  prev_use_s1;
	logic [twsm_pkg::CNT_W-1:0] cnt_q;
	logic                  out_valid_q;

	assign in_val[0] = shift_x;
	assign in_val[1] = shift_y;
	assign in_val[2] = turn;

	always_comb begin
		logic signed [AW:0] s;
		for (int c = 0; c < 3; c++) begin
			s = (cmd.run_clear ? '0 : {run_q[c][AW-1], run_q[c]})
				+ {{(AW-31){in_val[c][31]}}, in_val[c]};
			if (s[AW] != s[AW-1]) begin
				run_n[c] = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
			end else begin
				run_n[c] = s[AW-1:0];
			end
		end
	end

	assign wdata = {run_n[2], run_n[1], run_n[0]};

	twsm_ram #(.WIDTH(3 * AW), .DEPTH(twsm_pkg::RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (cmd.ram_waddr),
		.wdata (wdata),
		.raddr (cmd.ram_raddr),
		.rdata (rdata)
	);

	always_comb begin
		logic signed [RW-1:0] sq;
		logic signed [RW-1:0] r;
		for (int c = 0; c < 3; c++) begin
			sq = neg_q[c] ? -$signed({2'b00, quo_q[c]}) : $signed({2'b00, quo_q[c]});
			r  = sq - {{(RW-AW){prev_q[c][AW-1]}}, prev_q[c]};
			if (r[RW-1:31] != {(RW-31){r[RW-1]}}) begin
				res[c] = r[RW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				res[c] = r[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_rd_s1   <= 1'b0;
			prev_rd_s1  <= 1'b0;
			prev_use_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				run_q[c] <= '0;
			end
		end else begin
			sum_rd_s1   <= cmd.sum_rd;
			prev_rd_s1  <= cmd.prev_rd;
			prev_use_s1 <= cmd.prev_use;
			if (cmd.run_load) begin
				for (int c = 0; c < 3; c++) begin
					run_q[c] <= run_n[c];
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [6:0] sh;
		for (int c = 0; c < 3; c++) begin
			if (cmd.sum_clear) begin
				sum_q[c] <= '0;
			end else if (sum_rd_s1) begin
				sum_q[c] <= sum_q[c]
					+ {{(SW-AW){rdata[c*AW+AW-1]}}, rdata[c*AW +: AW]};
			end
			if (prev_rd_s1) begin
				prev_q[c] <= prev_use_s1 ? rdata[c*AW +: AW] : '0;
			end
			if (cmd.div_load) begin
				neg_q[c] <= sum_q[c][SW-1];
				quo_q[c] <= (sum_q[c][SW-1] ? DW'(-sum_q[c]) : DW'(sum_q[c]))
					+ DW'(cmd.count >> 1);
				rem_q[c] <= '0;
			end else if (cmd.div_step) begin
				sh = {rem_q[c], quo_q[c][DW-1]};
				if (sh >= cnt_q) begin
					rem_q[c] <= 6'(sh - cnt_q);
					quo_q[c] <= {quo_q[c][DW-2:0], 1'b1};
				end else begin
					rem_q[c] <= sh[5:0];
					quo_q[c] <= {quo_q[c][DW-2:0], 1'b0};
				end
			end
		end
		if (cmd.div_load) begin
			cnt_q <= cmd.count;
		end
		if (cmd.out_load) begin
			fixed_x      <= res[0];
			fixed_y      <= res[1];
			fixed_turn   <= res[2];
			sequence_end <= cmd.out_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;
endmodule
`default_nettype wire

[rtl/twsm_ctrl.sv]
// ----------------------------------------------------------------------------
// twsm_ctrl
// Sequencer: frame bookkeeping, window walk, divider steps and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module twsm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          in_final,
	input  wire logic          cfg_we,
	input  wire logic [4:0]    cfg_data,
	output twsm_pkg::cmd_t     cmd,
	input  wire twsm_pkg::sts_t sts
);
	typedef enum logic [2:0] {IDLE, SETUP, SUM, PREV, LOAD, DIV, FIN} state_t;

	state_t     state_q;
	logic [4:0] radius_q;
	logic [4:0] active_q;
	logic [5:0] pending_q;
	logic [5:0] next_q;
	logic [5:0] emitted_q;
	logic       final_q;
	logic [5:0] rd_addr_q;
	logic [6:0] left_q;
	logic [6:0] count_q;
	logic [5:0] step_q;
	logic       accept;
	logic       start;
	logic [4:0] active_n;
	logic [5:0] lo;
	logic [5:0] up;

	assign in_ready = (state_q == IDLE);
	assign accept   = in_valid && in_ready;
	assign start    = (pending_q == '0) && (emitted_q == '0);
	assign active_n = start ? radius_q : active_q;
	assign lo = (emitted_q < {1'b0, active_q}) ? emitted_q : {1'b0, active_q};
	assign up = ((pending_q - 6'd1) > {1'b0, active_q}) ? {1'b0, active_q}
		: pending_q - 6'd1;

	always_comb begin
		cmd           = '0;
		cmd.run_load  = accept;
		cmd.run_clear = start;
		cmd.ram_we    = accept;
		cmd.ram_waddr = next_q + pending_q;
		cmd.ram_raddr = rd_addr_q;
		cmd.count     = count_q;
		cmd.out_last  = final_q && (pending_q == 6'd1);
		unique case (state_q)
			IDLE: begin
			end
			SETUP: cmd.sum_clear = 1'b1;
			SUM: cmd.sum_rd = 1'b1;
			PREV: begin
				cmd.ram_raddr = next_q - 6'd1;
				cmd.prev_rd   = 1'b1;
				cmd.prev_use  = (emitted_q != '0);
			end
			LOAD: cmd.div_load = 1'b1;
			DIV: cmd.div_step = 1'b1;
			FIN: cmd.out_load = sts.out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			radius_q  <= twsm_pkg::RADIUS_RESET;
			active_q  <= twsm_pkg::RADIUS_RESET;
			pending_q <= '0;
			next_q    <= '0;
			emitted_q <= '0;
			final_q   <= 1'b0;
			rd_addr_q <= '0;
			left_q    <= '0;
			count_q   <= '0;
			step_q    <= '0;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_data;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						active_q  <= active_n;
						pending_q <= pending_q + 6'd1;
						final_q   <= in_final;
						if (in_final || ({1'b0, pending_q} + 7'd1 > {2'b00, active_n})) begin
							state_q <= SETUP;
						end
					end
				end
				SETUP: begin
					count_q   <= {1'b0, lo} + {1'b0, up} + 7'd1;
					left_q    <= {1'b0, lo} + {1'b0, up} + 7'd1;
					rd_addr_q <= next_q - lo;
					state_q   <= SUM;
				end
				SUM: begin
					rd_addr_q <= rd_addr_q + 6'd1;
					left_q    <= left_q - 7'd1;
					if (left_q == 7'd1) begin
						state_q <= PREV;
					end
				end
				PREV: state_q <= LOAD;
				LOAD: begin
					step_q  <= 6'(twsm_pkg::DIV_STEPS);
					state_q <= DIV;
				end
				DIV: begin
					step_q <= step_q - 6'd1;
					if (step_q == 6'd1) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					if (sts.out_free) begin
						next_q    <= next_q + 6'd1;
						pending_q <= pending_q - 6'd1;
						if (final_q && (pending_q != 6'd1)) begin
							emitted_q <= (emitted_q == 6'd63) ? emitted_q : emitted_q + 6'd1;
							state_q   <= SETUP;
						end else if (final_q) begin
							emitted_q <= '0;
							final_q   <= 1'b0;
							state_q   <= IDLE;
						end else begin
							emitted_q <= (emitted_q == 6'd63) ? emitted_q : emitted_q + 6'd1;
							state_q   <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 6'd32) else $error("Pending frame count exceeds the window.");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("Result loaded over a held result.");
	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SUM) |-> (left_q != '0 && pending_q != '0))
		else $error("Window walk with nothing to read.");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LOAD) |=> (state_q == DIV && step_q == 6'(twsm_pkg::DIV_STEPS)))
		else $error("Divider not started with its full step count.");
endmodule
`default_nettype wire
